// ===== sv/pvi_pkg.sv =====
// ----------------------------------------------------------------------------
// pvi_pkg: shared types and helpers for the polynomial value and integral block
// Fixed-point widths, the pipeline word passed between term stages, register
// codes and the saturation helper.
// ----------------------------------------------------------------------------
package pvi_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  // Six 32-bit terms summed exactly need three extra bits.
  localparam int ACC_W = DATA_W + 3;
  localparam int COEF_REGS = 6;
  localparam int CNT_W = 3;
  localparam int ADDR_W = 5;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    REG_TERM_COUNT = 3'd0,
    REG_COEF_0     = 3'd1,
    REG_COEF_1     = 3'd2,
    REG_COEF_2     = 3'd3,
    REG_COEF_3     = 3'd4,
    REG_COEF_4     = 3'd5,
    REG_COEF_5     = 3'd6
  } reg_index_t;

  // One pipeline word between term stages.
  typedef struct packed {
    logic valid;
    logic mode;
    fix_t a;    // first point
    fix_t y;    // multiplier of the upper power chain: x in mode 0, b in mode 1
    fix_t pa;   // a^(i+1) in mode 1, zero in mode 0
    fix_t pb;   // b^(i+1) in mode 1, x^i in mode 0
    fix_t d;    // saturated pb - pa for the coming term
    acc_t acc;
    logic ovf;
  } pvi_stage_t;

  typedef struct packed {
    logic ovf;
    fix_t value;
  } sat_t;

  localparam prod_t FIX_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam prod_t FIX_MIN_W = 64'shFFFF_FFFF_8000_0000;
  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  function automatic prod_t widen(input fix_t x);
    return {{(PROD_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic sat_t sat_fix(input prod_t v);
    sat_t r;
    if (v > FIX_MAX_W) begin
      r.ovf = 1'b1;
      r.value = FIX_MAX;
    end else if (v < FIX_MIN_W) begin
      r.ovf = 1'b1;
      r.value = FIX_MIN;
    end else begin
      r.ovf = 1'b0;
      r.value = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/pvi_term.sv =====
// ----------------------------------------------------------------------------
// pvi_term: one polynomial term, two register stages
// The first stage forms the raw products for the next powers and for this
// term; the second truncates and saturates them, accumulates the term and
// prepares the difference used by the following term.
// ----------------------------------------------------------------------------
module pvi_term #(
  parameter int FRAC_BITS = 16,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  pvi_pkg::pvi_stage_t stage_in,
  input  pvi_pkg::fix_t      coef,
  input  pvi_pkg::fix_t      scaled_coef,
  input  pvi_pkg::cnt_t      n_terms,
  output pvi_pkg::pvi_stage_t stage_out
);
  import pvi_pkg::*;

  localparam cnt_t THIS_TERM = cnt_t'(IDX);
  localparam cnt_t NEXT_TERM = cnt_t'(IDX + 1);

  logic  active;
  logic  next_active;
  fix_t  k;

  logic  mul_valid;
  logic  mul_mode;
  fix_t  mul_a;
  fix_t  mul_y;
  acc_t  mul_acc;
  logic  mul_ovf;
  prod_t mul_pa;
  prod_t mul_pb;
  prod_t mul_term;

  sat_t  pa_s;
  sat_t  pb_s;
  sat_t  term_s;
  sat_t  diff_s;
  pvi_stage_t stage_next;

  assign active = n_terms > THIS_TERM;
  assign next_active = n_terms > NEXT_TERM;
  assign k = stage_in.mode ? scaled_coef : coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= stage_in.valid;
      mul_mode  <= stage_in.mode;
      mul_a     <= stage_in.a;
      mul_y     <= stage_in.y;
      mul_acc   <= stage_in.acc;
      mul_ovf   <= stage_in.ovf;
      mul_pa    <= $signed(stage_in.pa) * $signed(stage_in.a);
      mul_pb    <= $signed(stage_in.pb) * $signed(stage_in.y);
      mul_term  <= $signed(stage_in.d) * $signed(k);
    end
  end

  // A power formed here only counts towards overflow if the next term uses it.
  always_comb begin
    pa_s   = sat_fix(mul_pa >>> FRAC_BITS);
    pb_s   = sat_fix(mul_pb >>> FRAC_BITS);
    term_s = sat_fix(mul_term >>> FRAC_BITS);
    diff_s = sat_fix(widen(pb_s.value) - widen(pa_s.value));
    stage_next.valid = mul_valid;
    stage_next.mode  = mul_mode;
    stage_next.a     = mul_a;
    stage_next.y     = mul_y;
    stage_next.pa    = pa_s.value;
    stage_next.pb    = pb_s.value;
    stage_next.d     = diff_s.value;
    stage_next.acc   = active
        ? mul_acc + {{(ACC_W-DATA_W){term_s.value[DATA_W-1]}}, term_s.value}
        : mul_acc;
    stage_next.ovf   = mul_ovf | (active & term_s.ovf)
        | (next_active & (pa_s.ovf | pb_s.ovf | diff_s.ovf));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out <= stage_next;
    end
  end

endmodule

// ===== sv/polynomial_value_and_integral.sv =====
// ----------------------------------------------------------------------------
// polynomial_value_and_integral: fixed-point polynomial value and integral
// Evaluates p(x) or the definite integral of p over [a, b] from up to six
// configured coefficients, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output is not stalled
// and returns each result through an input register, two stages per term
// (three 32x32 multipliers, then truncation, saturation and accumulation) and
// an output register. The whole pipeline advances together, so in_ready falls
// only while a result waits on a low out_ready. Configuration is to be written
// through the register port only while no word is in flight; the block itself
// does not enforce this. The scaled coefficients for integration are registered
// from the stored coefficients and follow each coefficient write in the next cycle.
module polynomial_value_and_integral #(
  parameter int MAX_TERMS = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pvi_pkg::ADDR_W-1:0]  paddr,
  input  logic [pvi_pkg::DATA_W-1:0]  pwdata,
  output logic [pvi_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  pvi_pkg::fix_t               first_point,
  input  pvi_pkg::fix_t               second_point,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pvi_pkg::fix_t               result_value,
  output logic                        overflow
);
  import pvi_pkg::*;

  localparam fix_t FIX_ONE = fix_t'(1 << FRAC_BITS);

  cnt_t       term_count;
  fix_t       coefficient [COEF_REGS];
  fix_t       scaled [COEF_REGS];
  reg_index_t reg_index;
  cnt_t       n_terms;
  logic       advance;
  sat_t       diff0;
  sat_t       sum_s;
  pvi_stage_t stage0_next;
  pvi_stage_t chain [MAX_TERMS+1];

  // Register port
  assign pready = 1'b1;
  assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= cnt_t'(1);
      for (int i = 0; i < COEF_REGS; i++) begin
        coefficient[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_TERM_COUNT: term_count <= pwdata[CNT_W-1:0];
        REG_COEF_0:     coefficient[0] <= pwdata;
        REG_COEF_1:     coefficient[1] <= pwdata;
        REG_COEF_2:     coefficient[2] <= pwdata;
        REG_COEF_3:     coefficient[3] <= pwdata;
        REG_COEF_4:     coefficient[4] <= pwdata;
        REG_COEF_5:     coefficient[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TERM_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, term_count};
      REG_COEF_0:     prdata = coefficient[0];
      REG_COEF_1:     prdata = coefficient[1];
      REG_COEF_2:     prdata = coefficient[2];
      REG_COEF_3:     prdata = coefficient[3];
      REG_COEF_4:     prdata = coefficient[4];
      REG_COEF_5:     prdata = coefficient[5];
      default:        prdata = '0;
    endcase
  end

  // Coefficients divided by (i+1) for integration. Every reciprocal is at most
  // one, so the scaled value always fits and needs no saturation.
  for (genvar g = 0; g < COEF_REGS; g++) begin : g_scale
    localparam int K = g + 1;
    localparam int RK = ((1 << FRAC_BITS) + K / 2) / K;
    localparam fix_t RECIP = fix_t'(RK);
    prod_t scale_prod;
    assign scale_prod = ($signed(coefficient[g]) * $signed(RECIP)) >>> FRAC_BITS;
    always_ff @(posedge clk) begin
      scaled[g] <= scale_prod[DATA_W-1:0];
    end
  end

  assign n_terms = (term_count > cnt_t'(MAX_TERMS)) ? cnt_t'(MAX_TERMS) : term_count;

  // The whole pipeline moves whenever the output register can take a word.
  assign advance = !out_valid || out_ready;
  assign in_ready = advance;

  // Input stage. In mode 0 the lower power chain is held at zero so that the
  // difference fed to each term is simply x^i.
  always_comb begin
    diff0 = sat_fix(widen(second_point) - widen(first_point));
    stage0_next.valid = in_valid;
    stage0_next.mode  = mode;
    stage0_next.a     = first_point;
    stage0_next.y     = mode ? second_point : first_point;
    stage0_next.pa    = mode ? first_point : '0;
    stage0_next.pb    = mode ? second_point : FIX_ONE;
    stage0_next.d     = mode ? diff0.value : FIX_ONE;
    stage0_next.acc   = '0;
    stage0_next.ovf   = mode & diff0.ovf & (n_terms != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (advance) begin
      chain[0] <= stage0_next;
    end
  end

  for (genvar t = 0; t < MAX_TERMS; t++) begin : g_term
    pvi_term #(
      .FRAC_BITS (FRAC_BITS),
      .IDX       (t)
    ) u_term (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .stage_in    (chain[t]),
      .coef        (coefficient[t]),
      .scaled_coef (scaled[t]),
      .n_terms     (n_terms),
      .stage_out   (chain[t+1])
    );
  end

  // Output register
  assign sum_s = sat_fix({{(PROD_W-ACC_W){chain[MAX_TERMS].acc[ACC_W-1]}},
                          chain[MAX_TERMS].acc});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid    <= chain[MAX_TERMS].valid;
      result_value <= sum_s.value;
      overflow     <= chain[MAX_TERMS].ovf | sum_s.ovf;
    end
  end

endmodule
